FILE: src/filtered_group_by_aggregation_core_defines.svh
// Assertion macros shared by the aggregation core.
// No dependencies.
`ifndef FILTERED_GROUP_BY_AGGREGATION_CORE_DEFINES_SVH
`define FILTERED_GROUP_BY_AGGREGATION_CORE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define FGA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next cycle.
`define FGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fga_pkg.sv
// Types and constants of the group-by aggregation core.
// No dependencies.
package fga_pkg;

  localparam int unsigned SumW   = 60;
  localparam int unsigned CountW = 32;
  localparam int unsigned TermW  = 40;

  typedef enum logic [1:0] {
    OP_ROW    = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Item as it leaves the front end: opcode plus precomputed row terms.
  typedef struct packed {
    op_e              op;
    logic [15:0]      key;
    logic [19:0]      qty;
    logic [23:0]      price;
    logic [6:0]       disc;
    logic [TermW-1:0] dprice;
    logic [6:0]       tax;
  } cmd_t;

  typedef struct packed {
    logic              present;
    logic [15:0]       key;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sum_qty;
    logic [SumW-1:0]   sum_price;
    logic [SumW-1:0]   sum_dprice;
    logic [SumW-1:0]   sum_charge;
    logic [SumW-1:0]   sum_disc;
    logic              ovf;
    logic              last;
  } res_t;

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [TermW-1:0] t);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW-TermW+1){1'b0}}, t};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

FILE: src/fga_front.sv
// Front end: filters rows by ship date, forms the key and the discounted price.
// Depends on fga_pkg.
module fga_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          return_flag_i,
  input  logic [7:0]          line_status_i,
  input  logic [19:0]         quantity_i,
  input  logic [23:0]         extended_price_i,
  input  logic [6:0]          discount_i,
  input  logic [6:0]          tax_i,
  input  logic [15:0]         ship_date_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output fga_pkg::cmd_t       cmd_o
);
  import fga_pkg::*;

  logic [15:0] cutoff_q;
  logic        valid_q;
  cmd_t        cmd_q;
  cmd_t        cmd_d;
  logic [6:0]  dfac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cutoff_q <= 16'hFFFF;
    else if (cfg_we_i) cutoff_q <= cfg_data_i;
  end

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign dfac = (discount_i > 7'd100) ? 7'd0 : 7'd100 - discount_i;

  always_comb begin
    cmd_d.op     = op_e'(opcode_i);
    // filtered rows become no-ops
    if (opcode_i == OP_ROW && ship_date_i > cutoff_q) cmd_d.op = OP_NONE;
    cmd_d.key    = {return_flag_i, line_status_i};
    cmd_d.qty    = quantity_i;
    cmd_d.price  = extended_price_i;
    cmd_d.disc   = discount_i;
    cmd_d.dprice = TermW'(extended_price_i) * TermW'(dfac);
    cmd_d.tax    = tax_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i && (op_e'(opcode_i) != OP_NONE);
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;
endmodule

FILE: src/fga_queue.sv
// Short queue between front and back end.
// Depends on fga_pkg.
module fga_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  fga_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output fga_pkg::cmd_t rd_data_o
);
  import fga_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr, rd;

  assign wr_ready_o = cnt_q != (AW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: src/fga_back.sv
// Back end: group table, charge multiply, saturating update, report sweep.
// Depends on fga_pkg.
module fga_back #(
  parameter int unsigned MaxGroups = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  fga_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output fga_pkg::res_t res_o
);
  import fga_pkg::*;

  localparam int unsigned IW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_UPDATE, ST_REPORT} state_e;

  state_e            state_q;
  logic [MaxGroups-1:0] valid_q;
  logic              ovf_q;
  logic [15:0]       key_q   [MaxGroups];
  logic [CountW-1:0] cnt_q   [MaxGroups];
  logic [SumW-1:0]   sq_q    [MaxGroups];
  logic [SumW-1:0]   sp_q    [MaxGroups];
  logic [SumW-1:0]   sd_q    [MaxGroups];
  logic [SumW-1:0]   sc_q    [MaxGroups];
  logic [SumW-1:0]   sk_q    [MaxGroups];
  cmd_t              cur_q;
  logic [TermW-1:0]  charge_q;
  logic [IW-1:0]     slot_q;
  logic              fresh_q;
  logic [IW:0]       idx_q;
  logic              rvalid_q;
  res_t              res_q;

  logic [MaxGroups-1:0] match;
  logic              hit, free;
  logic [IW-1:0]     hit_idx, free_idx;
  logic              rfree;

  always_comb begin
    hit = 1'b0; free = 1'b0; hit_idx = '0; free_idx = '0;
    for (int i = MaxGroups-1; i >= 0; i--) begin
      match[i] = valid_q[i] && key_q[i] == cmd_i.key;
      if (match[i]) begin hit = 1'b1; hit_idx = IW'(i); end
      if (!valid_q[i]) begin free = 1'b1; free_idx = IW'(i); end
    end
  end

  assign rfree = !rvalid_q || res_ready_i;
  assign cmd_ready_o = state_q == ST_IDLE;

  // report scan: next occupied entry at or above idx
  logic          more;
  logic [IW-1:0] nxt;
  logic          later;
  always_comb begin
    more = 1'b0; nxt = '0; later = 1'b0;
    for (int i = MaxGroups-1; i >= 0; i--) begin
      if (valid_q[i] && (IW+1)'(i) >= idx_q) begin more = 1'b1; nxt = IW'(i); end
    end
    for (int i = 0; i < MaxGroups; i++) begin
      if (valid_q[i] && IW'(i) > nxt) later = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      ovf_q    <= 1'b0;
      rvalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (state_q == ST_REPORT && rfree) rvalid_q <= 1'b1;
      else if (res_ready_i) rvalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              OP_ROW: begin
                if (hit || free) state_q <= ST_UPDATE;
                else ovf_q <= 1'b1;
                if (!hit && free) valid_q[free_idx] <= 1'b1;
              end
              OP_REPORT: begin
                state_q <= ST_REPORT;
                idx_q   <= '0;
              end
              OP_CLEAR: begin
                valid_q <= '0;
                ovf_q   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_UPDATE: state_q <= ST_IDLE;
        ST_REPORT: begin
          if (rfree) begin
            if (!more || !later) state_q <= ST_IDLE;
            idx_q <= (IW+1)'(nxt) + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cur_q    <= cmd_i;
      charge_q <= TermW'(cmd_i.dprice * (8'd100 + 8'(cmd_i.tax)));
      slot_q   <= hit ? hit_idx : free_idx;
      fresh_q  <= !hit;
    end
    if (state_q == ST_UPDATE) begin
      key_q[slot_q] <= cur_q.key;
      if (fresh_q) begin
        cnt_q[slot_q] <= CountW'(1);
        sq_q[slot_q]  <= SumW'(cur_q.qty);
        sp_q[slot_q]  <= SumW'(cur_q.price);
        sd_q[slot_q]  <= SumW'(cur_q.dprice);
        sc_q[slot_q]  <= SumW'(charge_q);
        sk_q[slot_q]  <= SumW'(cur_q.disc);
      end else begin
        if (cnt_q[slot_q] != '1) cnt_q[slot_q] <= cnt_q[slot_q] + 1'b1;
        sq_q[slot_q] <= sat_add(sq_q[slot_q], TermW'(cur_q.qty));
        sp_q[slot_q] <= sat_add(sp_q[slot_q], TermW'(cur_q.price));
        sd_q[slot_q] <= sat_add(sd_q[slot_q], cur_q.dprice);
        sc_q[slot_q] <= sat_add(sc_q[slot_q], charge_q);
        sk_q[slot_q] <= sat_add(sk_q[slot_q], TermW'(cur_q.disc));
      end
    end
    if (state_q == ST_REPORT && rfree) begin
      res_q.present    <= more;
      res_q.key        <= more ? key_q[nxt] : '0;
      res_q.count      <= more ? cnt_q[nxt] : '0;
      res_q.sum_qty    <= more ? sq_q[nxt] : '0;
      res_q.sum_price  <= more ? sp_q[nxt] : '0;
      res_q.sum_dprice <= more ? sd_q[nxt] : '0;
      res_q.sum_charge <= more ? sc_q[nxt] : '0;
      res_q.sum_disc   <= more ? sk_q[nxt] : '0;
      res_q.ovf        <= ovf_q;
      res_q.last       <= !more || !later;
    end
  end

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;
endmodule

FILE: src/filtered_group_by_aggregation_core.sv
// Top level of the filtered group-by aggregation core.
// Depends on fga_pkg, fga_front, fga_queue, fga_back and the defines header.
//
// Channel   Direction  Handshake
// input     in         push / full
// result    out        pop / empty
// config    in         cfg_we_i (write only)
//
// In the back end a row is handled in two steps: lookup/multiply, then table update.
// A report enters its sweep state, then emits one group per cycle while results are popped; clear acts on acceptance.
// Reset clears valid bits, the overflow flag and sets the cutoff to 65535.
// The front end keeps accepting while the queue has room; results wait in a
// register until popped, which stalls the report sweep.
`include "filtered_group_by_aggregation_core_defines.svh"
module filtered_group_by_aggregation_core #(
  parameter int unsigned MAX_GROUPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  return_flag_i,
  input  logic [7:0]  line_status_i,
  input  logic [19:0] quantity_i,
  input  logic [23:0] extended_price_i,
  input  logic [6:0]  discount_i,
  input  logic [6:0]  tax_i,
  input  logic [15:0] ship_date_i,
  output logic        empty,
  input  logic        pop,
  output logic        group_present_o,
  output logic [7:0]  out_return_flag_o,
  output logic [7:0]  out_line_status_o,
  output logic [31:0] row_count_o,
  output logic [59:0] sum_quantity_o,
  output logic [59:0] sum_base_price_o,
  output logic [59:0] sum_disc_price_o,
  output logic [59:0] sum_charge_o,
  output logic [59:0] sum_discount_o,
  output logic        table_overflow_o,
  output logic        is_last_o
);
  import fga_pkg::*;

  logic  in_ready, f_valid, f_ready, q_valid, q_ready, r_valid;
  cmd_t  f_cmd, q_cmd;
  res_t  res;

  fga_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i(push), .in_ready_o(in_ready),
    .opcode_i, .return_flag_i, .line_status_i, .quantity_i,
    .extended_price_i, .discount_i, .tax_i, .ship_date_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  fga_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  fga_back #(.MaxGroups(MAX_GROUPS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(r_valid), .res_ready_i(pop), .res_o(res)
  );

  assign full              = !in_ready;
  assign empty             = !r_valid;
  assign group_present_o   = res.present;
  assign out_return_flag_o = res.key[15:8];
  assign out_line_status_o = res.key[7:0];
  assign row_count_o       = res.count;
  assign sum_quantity_o    = res.sum_qty;
  assign sum_base_price_o  = res.sum_price;
  assign sum_disc_price_o  = res.sum_dprice;
  assign sum_charge_o      = res.sum_charge;
  assign sum_discount_o    = res.sum_disc;
  assign table_overflow_o  = res.ovf;
  assign is_last_o         = res.last;

  `FGA_ASSERT(a_empty_report_last, clk_i, rst_ni, empty || group_present_o || is_last_o, "absent group not last")
  `FGA_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty && !pop, !empty, "result dropped before pop")
  `FGA_ASSERT_NEXT(a_queue_overrun, clk_i, rst_ni, f_valid && !f_ready, f_valid, "front item lost")
endmodule

FILE: tb/fga_checker.sv
// Checker for the filtered group-by aggregation core: watches the item,
// config and result transfers, predicts results and compares them. Uses fga_pkg.
`timescale 1ns / 1ps
module fga_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  return_flag_i,
  input  logic [7:0]  line_status_i,
  input  logic [19:0] quantity_i,
  input  logic [23:0] extended_price_i,
  input  logic [6:0]  discount_i,
  input  logic [6:0]  tax_i,
  input  logic [15:0] ship_date_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        group_present_o,
  input  logic [7:0]  out_return_flag_o,
  input  logic [7:0]  out_line_status_o,
  input  logic [31:0] row_count_o,
  input  logic [59:0] sum_quantity_o,
  input  logic [59:0] sum_base_price_o,
  input  logic [59:0] sum_disc_price_o,
  input  logic [59:0] sum_charge_o,
  input  logic [59:0] sum_discount_o,
  input  logic        table_overflow_o,
  input  logic        is_last_o,
  input  logic        final_check_i,
  output int          fail_count_o,
  output int          pending_o
);
  import fga_pkg::*;

  localparam int NumGroups = 8;
  localparam logic [59:0] SumMax = {60{1'b1}};

  logic [15:0] cutoff;
  logic        grp_valid [NumGroups];
  logic [15:0] grp_key   [NumGroups];
  logic [31:0] grp_count [NumGroups];
  logic [59:0] grp_qty   [NumGroups];
  logic [59:0] grp_price [NumGroups];
  logic [59:0] grp_dprice[NumGroups];
  logic [59:0] grp_charge[NumGroups];
  logic [59:0] grp_disc  [NumGroups];
  logic        ovf_seen;
  res_t        summary_q[$];
  bit          final_done;

  assign pending_o = summary_q.size();

  function automatic logic [59:0] sat_sum(logic [59:0] a, logic [59:0] t);
    logic [60:0] s;
    s = {1'b0, a} + {1'b0, t};
    return s[60] ? SumMax : s[59:0];
  endfunction

  task automatic accumulate_row();
    logic [15:0] key;
    logic [59:0] dfac, dprice, charge;
    int slot;
    key = {return_flag_i, line_status_i};
    slot = -1;
    if (ship_date_i > cutoff) return;
    for (int i = 0; i < NumGroups; i++)
      if (slot < 0 && grp_valid[i] && grp_key[i] == key) slot = i;
    if (slot < 0) begin
      for (int i = 0; i < NumGroups; i++)
        if (slot < 0 && !grp_valid[i]) slot = i;
      if (slot < 0) begin
        ovf_seen = 1'b1;
        return;
      end
      grp_valid[slot] = 1'b1;
      grp_key[slot] = key;
      grp_count[slot] = '0;
      grp_qty[slot] = '0;
      grp_price[slot] = '0;
      grp_dprice[slot] = '0;
      grp_charge[slot] = '0;
      grp_disc[slot] = '0;
    end
    dfac = (discount_i > 7'd100) ? 60'd0 : 60'd100 - discount_i;
    dprice = extended_price_i * dfac;
    charge = dprice * (60'd100 + tax_i);
    if (grp_count[slot] != 32'hFFFF_FFFF) grp_count[slot]++;
    grp_qty[slot] = sat_sum(grp_qty[slot], quantity_i);
    grp_price[slot] = sat_sum(grp_price[slot], extended_price_i);
    grp_dprice[slot] = sat_sum(grp_dprice[slot], dprice);
    grp_charge[slot] = sat_sum(grp_charge[slot], charge);
    grp_disc[slot] = sat_sum(grp_disc[slot], discount_i);
  endtask

  task automatic queue_summary();
    res_t r;
    int n;
    n = 0;
    for (int i = 0; i < NumGroups; i++) begin
      if (grp_valid[i]) begin
        r = '0;
        r.present = 1'b1;
        r.key = grp_key[i];
        r.count = grp_count[i];
        r.sum_qty = grp_qty[i];
        r.sum_price = grp_price[i];
        r.sum_dprice = grp_dprice[i];
        r.sum_charge = grp_charge[i];
        r.sum_disc = grp_disc[i];
        r.ovf = ovf_seen;
        summary_q.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      r.ovf = ovf_seen;
      summary_q.push_back(r);
    end
    summary_q[summary_q.size()-1].last = 1'b1;
  endtask

  task automatic field_chk(string name, logic [59:0] exp_v, logic [59:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    res_t e;
    if (summary_q.size() == 0) begin
      $error("result transfer with nothing expected");
      fail_count_o++;
      return;
    end
    e = summary_q.pop_front();
    field_chk("group_present", e.present, group_present_o);
    field_chk("out_return_flag", e.key[15:8], out_return_flag_o);
    field_chk("out_line_status", e.key[7:0], out_line_status_o);
    field_chk("row_count", e.count, row_count_o);
    field_chk("sum_quantity", e.sum_qty, sum_quantity_o);
    field_chk("sum_base_price", e.sum_price, sum_base_price_o);
    field_chk("sum_disc_price", e.sum_dprice, sum_disc_price_o);
    field_chk("sum_charge", e.sum_charge, sum_charge_o);
    field_chk("sum_discount", e.sum_disc, sum_discount_o);
    field_chk("table_overflow", e.ovf, table_overflow_o);
    field_chk("is_last", e.last, is_last_o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff <= 16'hFFFF;
      ovf_seen = 1'b0;
      for (int i = 0; i < NumGroups; i++) grp_valid[i] = 1'b0;
      summary_q.delete();
      fail_count_o <= 0;
      final_done = 1'b0;
    end else begin
      if (pop && !empty) check_result();
      if (cfg_we_i) cutoff <= cfg_data_i;
      if (push && !full) begin
        case (op_e'(opcode_i))
          OP_ROW:    accumulate_row();
          OP_REPORT: queue_summary();
          OP_CLEAR: begin
            for (int i = 0; i < NumGroups; i++) grp_valid[i] = 1'b0;
            ovf_seen = 1'b0;
          end
          default: ;
        endcase
      end
      if (final_check_i && !final_done) begin
        final_done = 1'b1;
        if (summary_q.size() != 0) begin
          $error("%0d expected results never arrived", summary_q.size());
          fail_count_o++;
        end
      end
    end
  end
endmodule

FILE: tb/filtered_group_by_aggregation_core_tb.sv
// Stimulus and verdict for the filtered group-by aggregation core.
// Depends on fga_pkg, fga_checker and the core RTL.
`timescale 1ns / 1ps
module filtered_group_by_aggregation_core_tb;
  import fga_pkg::*;

  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] opcode_i = '0;
  logic [7:0] return_flag_i = '0, line_status_i = '0;
  logic [19:0] quantity_i = '0;
  logic [23:0] extended_price_i = '0;
  logic [6:0] discount_i = '0, tax_i = '0;
  logic [15:0] ship_date_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic group_present_o, table_overflow_o, is_last_o;
  logic [7:0] out_return_flag_o, out_line_status_o;
  logic [31:0] row_count_o;
  logic [59:0] sum_quantity_o, sum_base_price_o, sum_disc_price_o;
  logic [59:0] sum_charge_o, sum_discount_o;
  logic final_check = 1'b0;
  int fail_count, pending;
  int idle_pct = 32;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  filtered_group_by_aggregation_core u_top (.*);
  fga_checker u_chk (.*, .final_check_i(final_check), .fail_count_o(fail_count),
    .pending_o(pending));

  // result side stalls at random
  always @(negedge clk_i) pop <= rst_ni && ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // push stays high into the next call unless it idles; drain drops it
  task automatic send(op_e op, logic [7:0] rf, logic [7:0] ls, logic [19:0] q,
                      logic [23:0] p, logic [6:0] d, logic [6:0] t, logic [15:0] sd);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    return_flag_i <= rf;
    line_status_i <= ls;
    quantity_i <= q;
    extended_price_i <= p;
    discount_i <= d;
    tax_i <= t;
    ship_date_i <= sd;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic send_rand_row(int nkeys);
    send(OP_ROW, 8'(8'h41 + $urandom_range(nkeys)), 8'(8'h4E + $urandom_range(1)),
      20'($urandom), 24'($urandom), 7'($urandom_range(110)), 7'($urandom_range(127)),
      16'($urandom));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_cutoff(logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: empty report, extremes, saturation-ish values, bad discount
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    send(OP_ROW, 8'hFF, 8'hFF, '1, '1, 7'd0, 7'd127, 16'hFFFF);
    send(OP_ROW, 8'hFF, 8'hFF, '1, '1, 7'd127, 7'd100, 16'h0000);
    send(OP_ROW, 8'h00, 8'h00, 0, 0, 7'd100, 7'd0, 16'h1234);
    send(OP_NONE, 8'h12, 8'h34, 5, 5, 5, 5, 5);
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++)
      send(OP_ROW, 8'(8'h50 + i), 8'hAA, 20'(i), 24'(100 * i), 7'(i), 7'(i), 16'(i));
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    set_cutoff(16'd0);
    send(OP_ROW, 8'h41, 8'h46, 1, 1, 1, 1, 16'd1);
    send(OP_ROW, 8'h41, 8'h46, 2, 2, 2, 2, 16'd0);
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    set_cutoff(16'd30000);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    // random: row bursts ending in reports, with some clears and noise
    for (int n = 0; n < 88; n++) begin
      int r;
      r = $urandom_range(99);
      if (n == 40) drain();
      if (n == 50) idle_pct = 0;
      if (n == 75) idle_pct = 32;
      if (n == 60) set_cutoff(16'hFFFF);
      if (n == 80) set_cutoff(16'd45000);
      if (r < 70) send_rand_row(n < 60 ? 3 : 9);
      else if (r < 88) send(OP_REPORT, 8'($urandom), 8'($urandom), 20'($urandom),
        24'($urandom), 7'($urandom), 7'($urandom), 16'($urandom));
      else if (r < 95) send(OP_CLEAR, 8'($urandom), 8'($urandom), 0, 0, 0, 0, 0);
      else send(OP_NONE, 8'($urandom), 8'($urandom), 20'($urandom), 24'($urandom),
        7'($urandom), 7'($urandom), 16'($urandom));
    end
    send(OP_REPORT, 0, 0, 0, 0, 0, 0, 0);
    drain();
    final_check <= 1'b1;
    repeat (3) @(negedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/fga_pkg.sv
src/fga_front.sv
src/fga_queue.sv
src/fga_back.sv
src/filtered_group_by_aggregation_core.sv
tb/fga_checker.sv
tb/filtered_group_by_aggregation_core_tb.sv
